>>> rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// types and constants shared by the hash table controller and datapath
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [1:0] MARK_EMPTY    = 2'd0;
  localparam logic [1:0] MARK_OCCUPIED = 2'd1;
  localparam logic [1:0] MARK_DELETED  = 2'd2;

  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        key_bytes;
    logic [3:0]         key_length;
    logic signed [31:0] data_value;
  } lpht_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         occupied_count;
  } lpht_out_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;      // mark slot at probe position empty, step position
    logic load;       // capture request, start hash
    logic hash_step;  // absorb one key byte
    logic home;       // set probe position to home slot
    logic rd_issue;   // read slot at probe position
    logic advance;    // step probe position
    logic wr_update;  // overwrite value at hit
    logic wr_insert;  // fill the free slot
    logic wr_remove;  // mark hit deleted
    logic note_free;  // remember probe position as first free
    logic result;     // form the result
  } lpht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clear_last;
    logic       hash_done;
    logic [1:0] mode;
    logic [1:0] mark;
    logic       match;
    logic       have_free;
    logic       probe_last;
  } lpht_sts_t;

endpackage

>>> rtl/lpht_datapath.sv
// ----------------------------------------------------------------------------
// lpht_datapath
// key capture, byte-serial djb2 hash, slot memories and probe position
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int CAPACITY      = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpht_pkg::lpht_in_t  in_data,
  input  lpht_pkg::lpht_cmd_t cmd,
  output lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_out_t out_data
);
  import lpht_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [63:0] slot_key   [CAPACITY];
  logic [3:0]  slot_len   [CAPACITY];
  logic [31:0] slot_value [CAPACITY];
  logic [1:0]  slot_mark_r [CAPACITY];

  logic [1:0]  mode_r;
  logic [63:0] key_r;
  logic [3:0]  len_r;
  logic [31:0] val_r;
  logic [31:0] hash_r;
  logic [3:0]  idx_r;
  logic        hdone_r;
  logic [AW-1:0] pos_r, free_r;
  logic [AW:0]   nprobe_r;
  logic          free_v_r;
  logic [63:0] rd_key_r;
  logic [3:0]  rd_len_r;
  logic [31:0] rd_val_r;
  logic [1:0]  rd_mark_r;
  logic [AW-1:0] rd_pos_r;
  logic [CW-1:0] count_r;
  lpht_out_t   out_r;
  logic [1:0]  status_r;

  logic [3:0]  sat_len;
  logic [7:0]  cur_byte;
  logic [63:0] mask_key;
  logic [63:0] cut_key;
  logic        lookup_hit;

  assign sat_len = (in_data.key_length > 4'(MAX_KEY_BYTES)) ?
                   4'(MAX_KEY_BYTES) : in_data.key_length;
  assign cur_byte = key_r[idx_r[2:0]*8 +: 8];
  assign lookup_hit = (mode_r == MODE_LOOKUP) && sts.match;

  always_comb begin
    mask_key = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < sat_len) mask_key[i*8 +: 8] = in_data.key_bytes[i*8 +: 8];
    end
  end

  // key bytes kept ahead of the first zero byte
  always_comb begin
    cut_key = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < idx_r) cut_key[i*8 +: 8] = key_r[i*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      count_r <= '0;
      hdone_r <= 1'b0;
      free_v_r <= 1'b0;
      status_r <= STATUS_NOT_FOUND;
    end else begin
      if (cmd.clear) begin
        slot_mark_r[pos_r] <= MARK_EMPTY;
        pos_r <= (pos_r == AW'(CAPACITY - 1)) ? '0 : pos_r + 1'b1;
      end
      if (cmd.load) begin
        mode_r  <= in_data.mode;
        key_r   <= mask_key;
        len_r   <= sat_len;
        val_r   <= in_data.data_value;
        hash_r  <= HASH_SEED;
        idx_r   <= '0;
        hdone_r <= (sat_len == 4'd0);
        free_v_r <= 1'b0;
        status_r <= STATUS_NOT_FOUND;
      end
      if (cmd.hash_step) begin
        // a zero byte ends the key early
        if (cur_byte == 8'd0) begin
          hdone_r <= 1'b1;
          len_r   <= idx_r;
          key_r   <= cut_key;
        end else begin
          hash_r <= (hash_r << 5) + hash_r + {24'd0, cur_byte};
          idx_r  <= idx_r + 4'd1;
          if (idx_r + 4'd1 == len_r) hdone_r <= 1'b1;
        end
      end
      if (cmd.home) begin
        pos_r    <= AW'(hash_r % CAPACITY);
        nprobe_r <= '0;
      end
      if (cmd.rd_issue) begin
        rd_key_r  <= slot_key[pos_r];
        rd_len_r  <= slot_len[pos_r];
        rd_val_r  <= slot_value[pos_r];
        rd_mark_r <= slot_mark_r[pos_r];
        rd_pos_r  <= pos_r;
      end
      if (cmd.note_free) begin
        free_r   <= rd_pos_r;
        free_v_r <= 1'b1;
      end
      if (cmd.advance) begin
        pos_r    <= (pos_r == AW'(CAPACITY - 1)) ? '0 : pos_r + 1'b1;
        nprobe_r <= nprobe_r + 1'b1;
      end
      if (cmd.wr_update) begin
        slot_value[rd_pos_r] <= val_r;
        status_r <= STATUS_OK;
      end
      if (cmd.wr_insert) begin
        if (free_v_r) begin
          slot_key[free_r]    <= key_r;
          slot_len[free_r]    <= len_r;
          slot_value[free_r]  <= val_r;
          slot_mark_r[free_r] <= MARK_OCCUPIED;
          count_r <= count_r + 1'b1;
          status_r <= STATUS_OK;
        end else begin
          status_r <= STATUS_FULL;
        end
      end
      if (cmd.wr_remove) begin
        slot_mark_r[rd_pos_r] <= MARK_DELETED;
        count_r <= count_r - 1'b1;
        status_r <= STATUS_OK;
      end
      // a lookup ends on its hit, so the last slot read decides it
      if (cmd.result) begin
        out_r.status <= lookup_hit ? STATUS_OK : status_r;
        out_r.read_value <= lookup_hit ? rd_val_r : '0;
        out_r.occupied_count <= 7'(count_r);
      end
    end
  end

  assign sts.clear_last = (pos_r == AW'(CAPACITY - 1));
  assign sts.hash_done  = hdone_r;
  assign sts.mode       = mode_r;
  assign sts.mark       = rd_mark_r;
  assign sts.match      = (rd_mark_r == MARK_OCCUPIED) && (rd_len_r == len_r) &&
                          (rd_key_r == key_r);
  assign sts.have_free  = free_v_r;
  assign sts.probe_last = (nprobe_r == (AW+1)'(CAPACITY));
  assign out_data       = out_r;

endmodule

>>> rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// request sequencer: hash, probe walk, slot update and result handoff
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_ISSUE, S_CHECK, S_RESULT, S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign accept    = (state_r == S_IDLE) && in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_HASH: begin
        if (sts.hash_done) cmd.home = 1'b1;
        else cmd.hash_step = 1'b1;
      end
      S_ISSUE: begin
        if (!sts.probe_last) cmd.rd_issue = 1'b1;
        else if (sts.mode == MODE_INSERT) cmd.wr_insert = 1'b1;
      end
      S_CHECK: begin
        if (sts.match) begin
          if (sts.mode == MODE_INSERT) cmd.wr_update = 1'b1;
          else if (sts.mode == MODE_REMOVE) cmd.wr_remove = 1'b1;
        end else begin
          if (sts.mark != MARK_OCCUPIED && !sts.have_free) cmd.note_free = 1'b1;
          if (sts.mark == MARK_EMPTY) begin
            if (sts.mode == MODE_INSERT) cmd.wr_insert = !sts.have_free ? 1'b0 : 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_RESULT: cmd.result = 1'b1;
      S_OUT:    cmd = '0;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: if (sts.clear_last) state_r <= S_IDLE;
        S_IDLE: if (accept) state_r <= S_HASH;
        S_HASH: begin
          if (sts.hash_done) begin
            state_r <= (sts.mode == MODE_INSERT || sts.mode == MODE_REMOVE ||
                        sts.mode == MODE_LOOKUP) ? S_ISSUE : S_RESULT;
          end
        end
        S_ISSUE: state_r <= sts.probe_last ? S_RESULT : S_CHECK;
        S_CHECK: begin
          if (sts.match) state_r <= S_RESULT;
          else if (sts.mark == MARK_EMPTY) begin
            // insert at the empty slot itself when nothing was noted earlier
            state_r <= (sts.mode == MODE_INSERT && !sts.have_free) ? S_ISSUE : S_RESULT;
          end else state_r <= S_ISSUE;
        end
        S_RESULT: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing key/value table with djb2 home slot and linear probing
// ----------------------------------------------------------------------------
// One request at a time. After reset the slot marks are cleared one per cycle,
// so the input stays stalled until every slot is cleared. A request hashes
// its key, of length L bytes up to its first zero byte (the djb2 hash absorbs
// one byte per cycle), then probes P slots (one registered slot read and one
// compare per probe step); an insert that meets an empty slot before any
// deleted one reads that slot twice. The result waits in an output register
// until taken.
module linear_probe_hash_table #(
  parameter int CAPACITY      = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpht_pkg::lpht_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpht_pkg::lpht_out_t out_data
);
  import lpht_pkg::*;

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  lpht_datapath #(.CAPACITY(CAPACITY), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );

endmodule
